// File: rtl/tbo_pkg.sv
// Shared constants for the triangle versus box overlap test.
package tbo_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_BOX_LOW_X  = 3'd0;
    localparam cfg_idx_t REG_BOX_LOW_Y  = 3'd1;
    localparam cfg_idx_t REG_BOX_LOW_Z  = 3'd2;
    localparam cfg_idx_t REG_BOX_HIGH_X = 3'd3;
    localparam cfg_idx_t REG_BOX_HIGH_Y = 3'd4;
    localparam cfg_idx_t REG_BOX_HIGH_Z = 3'd5;

    // Pipeline depth from request to result register
    localparam int NUM_STAGES = 7;

endpackage

// File: rtl/triangle_box_overlap_test.sv
// Triangle versus axis-aligned box overlap test, separating axis method, pipelined.
//
//  channel | direction | handshake                 | payload
//  s_      | in        | s_tvalid / s_tready       | s_tdata: nine vertex coordinates
//  m_      | out       | m_tvalid / m_tready       | m_tdata: overlap flag
//  cfg_    | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data: box corners
//
// One request enters per cycle while the pipeline is not stalled; its result reaches the
// output register through seven register stages: centering, edges, products, sums,
// axis tests and plane partial products, plane sums, final compare.
// Reset (aresetn low at a clock edge) empties the pipeline and clears the box to 0.
// When the output register holds a result that is not taken, the whole pipeline
// holds; s_tready is low exactly then.
module triangle_box_overlap_test
    import tbo_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // s_tdata fields, low bit up: vert0_x, vert0_y, vert0_z, vert1_x, vert1_y,
    // vert1_z, vert2_x, vert2_y, vert2_z, then zero fill to whole bytes
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // m_tdata fields, low bit up: overlaps, then zero fill
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  cfg_idx_t                   cfg_index,
    input  logic [COORD_BITS-1:0]      cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int VW   = CB + 2;           // centered doubled vertex
    localparam int HW   = CB + 1;           // doubled half size
    localparam int EW   = CB + 3;           // edge component
    localparam int CW   = VW + 1;           // box axis compare
    localparam int P1W  = EW + VW;          // edge axis projection product
    localparam int RPW  = HW + EW;          // edge axis radius product
    localparam int PSW  = P1W + 1;          // projection and radius sums
    localparam int QW   = PSW + 1;          // edge axis compare
    localparam int NPW  = 2 * EW;           // normal product
    localparam int NW   = NPW + 1;          // normal component
    localparam int L    = CB + 3;           // split point of normal
    localparam int PLW  = L + 1 + VW;
    localparam int PHW  = NW - L + VW;
    localparam int PRLW = L + 1 + HW;
    localparam int PRHW = NW + 1 - L + HW;
    localparam int SW   = NW + VW + 3;      // plane sums

    // ------------------------------------------------------------------
    // Box registers
    // ------------------------------------------------------------------
    logic signed [CB-1:0] box_low_reg[3];
    logic signed [CB-1:0] box_high_reg[3];

    assign cfg_ready = 1'b1;

    // Write the box corners
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_low_reg[i]  <= '0;
                box_high_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BOX_LOW_X:  box_low_reg[0]  <= $signed(cfg_data);
                REG_BOX_LOW_Y:  box_low_reg[1]  <= $signed(cfg_data);
                REG_BOX_LOW_Z:  box_low_reg[2]  <= $signed(cfg_data);
                REG_BOX_HIGH_X: box_high_reg[0] <= $signed(cfg_data);
                REG_BOX_HIGH_Y: box_high_reg[1] <= $signed(cfg_data);
                REG_BOX_HIGH_Z: box_high_reg[2] <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1] valid_reg;
    logic                adv;

    assign adv      = !valid_reg[NUM_STAGES] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NUM_STAGES];

    // Advance valid bits together with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NUM_STAGES-1:1], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: center and double the vertices, doubled half size
    // ------------------------------------------------------------------
    logic signed [VW-1:0] v1_next[9], v1_reg[9];
    logic signed [HW-1:0] h1_next[3], h1_reg[3];

    for (genvar i = 0; i < 3; i++) begin : g_s1_axis
        assign h1_next[i] = HW'(box_high_reg[i]) - HW'(box_low_reg[i]);
        for (genvar k = 0; k < 3; k++) begin : g_s1_vert
            assign v1_next[k*3+i] =
                (VW'($signed(s_tdata[(k*3+i)*CB +: CB])) <<< 1)
                - (VW'(box_low_reg[i]) + VW'(box_high_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v1_reg <= v1_next;
            h1_reg <= h1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: edges and box axis tests
    // ------------------------------------------------------------------
    logic signed [VW-1:0] v2_reg[9];
    logic signed [HW-1:0] h2_reg[3];
    logic signed [EW-1:0] e2_next[9], e2_reg[9];
    logic [2:0]           bapart;
    logic                 bsep2_reg;

    for (genvar k = 0; k < 3; k++) begin : g_s2_edge
        for (genvar i = 0; i < 3; i++) begin : g_s2_comp
            assign e2_next[k*3+i] = EW'(v1_reg[((k+1)%3)*3+i]) - EW'(v1_reg[k*3+i]);
        end
    end

    // Check each box axis for a gap
    for (genvar i = 0; i < 3; i++) begin : g_s2_box
        logic signed [CW-1:0] a0, a1, a2, mn, mx, hh;
        always_comb begin
            a0 = CW'(v1_reg[i]);
            a1 = CW'(v1_reg[3+i]);
            a2 = CW'(v1_reg[6+i]);
            hh = CW'(h1_reg[i]);
            mn = a0;
            mx = a0;
            if (a1 < mn) mn = a1;
            if (a2 < mn) mn = a2;
            if (a1 > mx) mx = a1;
            if (a2 > mx) mx = a2;
            bapart[i] = (hh < mn) || (mx < -hh);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v2_reg    <= v1_reg;
            h2_reg    <= h1_reg;
            e2_reg    <= e2_next;
            bsep2_reg <= |bapart;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products for edge axes and the normal
    // ------------------------------------------------------------------
    logic signed [EW-1:0]  eabs[9];
    logic signed [P1W-1:0] mp1_next[27], mp2_next[27], mp1_reg[27], mp2_reg[27];
    logic signed [RPW-1:0] rp1_next[9], rp2_next[9], rp1_reg[9], rp2_reg[9];
    logic signed [NPW-1:0] np1_next[3], np2_next[3], np1_reg[3], np2_reg[3];
    logic signed [VW-1:0]  v3_reg[3];
    logic signed [HW-1:0]  h3_reg[3];
    logic                  bsep3_reg;

    for (genvar n = 0; n < 9; n++) begin : g_s3_abs
        assign eabs[n] = e2_reg[n][EW-1] ? -e2_reg[n] : e2_reg[n];
    end

    for (genvar k = 0; k < 3; k++) begin : g_s3_edge
        for (genvar j = 0; j < 3; j++) begin : g_s3_axis
            localparam int A = (j + 1) % 3;
            localparam int B = (j + 2) % 3;
            assign rp1_next[k*3+j] = RPW'(h2_reg[A]) * RPW'(eabs[k*3+B]);
            assign rp2_next[k*3+j] = RPW'(h2_reg[B]) * RPW'(eabs[k*3+A]);
            for (genvar m = 0; m < 3; m++) begin : g_s3_vert
                assign mp1_next[(k*3+j)*3+m] =
                    P1W'(e2_reg[k*3+B]) * P1W'(v2_reg[m*3+A]);
                assign mp2_next[(k*3+j)*3+m] =
                    P1W'(e2_reg[k*3+A]) * P1W'(v2_reg[m*3+B]);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_s3_nrm
        localparam int A = (i + 1) % 3;
        localparam int B = (i + 2) % 3;
        assign np1_next[i] = NPW'(e2_reg[A]) * NPW'(e2_reg[3+B]);
        assign np2_next[i] = NPW'(e2_reg[B]) * NPW'(e2_reg[3+A]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mp1_reg   <= mp1_next;
            mp2_reg   <= mp2_next;
            rp1_reg   <= rp1_next;
            rp2_reg   <= rp2_next;
            np1_reg   <= np1_next;
            np2_reg   <= np2_next;
            for (int i = 0; i < 3; i++) begin
                v3_reg[i] <= v2_reg[i];
            end
            h3_reg    <= h2_reg;
            bsep3_reg <= bsep2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: projections, radii and the normal
    // ------------------------------------------------------------------
    logic signed [PSW-1:0] p4_next[27], p4_reg[27];
    logic signed [PSW-1:0] r4_next[9], r4_reg[9];
    logic signed [NW-1:0]  n4_next[3], n4_reg[3];
    logic signed [VW-1:0]  v4_reg[3];
    logic signed [HW-1:0]  h4_reg[3];
    logic                  bsep4_reg;

    for (genvar q = 0; q < 27; q++) begin : g_s4_proj
        assign p4_next[q] = PSW'(mp1_reg[q]) - PSW'(mp2_reg[q]);
    end
    for (genvar q = 0; q < 9; q++) begin : g_s4_rad
        assign r4_next[q] = PSW'(rp1_reg[q]) + PSW'(rp2_reg[q]);
    end
    for (genvar i = 0; i < 3; i++) begin : g_s4_nrm
        assign n4_next[i] = NW'(np1_reg[i]) - NW'(np2_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_reg    <= p4_next;
            r4_reg    <= r4_next;
            n4_reg    <= n4_next;
            v4_reg    <= v3_reg;
            h4_reg    <= h3_reg;
            bsep4_reg <= bsep3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: edge axis tests, plane partial products
    // ------------------------------------------------------------------
    logic [8:0]             eapart;
    logic signed [PLW-1:0]  pl_lo_next[3], pl_lo_reg[3];
    logic signed [PHW-1:0]  pl_hi_next[3], pl_hi_reg[3];
    logic signed [PRLW-1:0] pr_lo_next[3], pr_lo_reg[3];
    logic signed [PRHW-1:0] pr_hi_next[3], pr_hi_reg[3];
    logic                   sep5_reg;

    // Check each edge cross axis for a gap
    for (genvar q = 0; q < 9; q++) begin : g_s5_edge
        logic signed [QW-1:0] a0, a1, a2, mn, mx, rr;
        always_comb begin
            a0 = QW'(p4_reg[q*3]);
            a1 = QW'(p4_reg[q*3+1]);
            a2 = QW'(p4_reg[q*3+2]);
            rr = QW'(r4_reg[q]);
            mn = a0;
            mx = a0;
            if (a1 < mn) mn = a1;
            if (a2 < mn) mn = a2;
            if (a1 > mx) mx = a1;
            if (a2 > mx) mx = a2;
            eapart[q] = (rr < mn) || (mx < -rr);
        end
    end

    // Split the normal so each multiply stays narrow
    for (genvar i = 0; i < 3; i++) begin : g_s5_plane
        logic signed [NW:0]     nabs;
        logic signed [L:0]      nlo, alo;
        logic signed [NW-L-1:0] nhi;
        logic signed [NW-L:0]   ahi;
        always_comb begin
            nabs = n4_reg[i][NW-1] ? -(NW+1)'(n4_reg[i]) : (NW+1)'(n4_reg[i]);
            nlo  = $signed({1'b0, n4_reg[i][L-1:0]});
            nhi  = $signed(n4_reg[i][NW-1:L]);
            alo  = $signed({1'b0, nabs[L-1:0]});
            ahi  = $signed(nabs[NW:L]);
        end
        assign pl_lo_next[i] = PLW'(nlo) * PLW'(v4_reg[i]);
        assign pl_hi_next[i] = PHW'(nhi) * PHW'(v4_reg[i]);
        assign pr_lo_next[i] = PRLW'(alo) * PRLW'(h4_reg[i]);
        assign pr_hi_next[i] = PRHW'(ahi) * PRHW'(h4_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_lo_reg <= pl_lo_next;
            pl_hi_reg <= pl_hi_next;
            pr_lo_reg <= pr_lo_next;
            pr_hi_reg <= pr_hi_next;
            sep5_reg  <= bsep4_reg | (|eapart);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: plane offset of vertex 0 and box radius along the normal
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s6_next, s6_reg, r6_next, r6_reg;
    logic                 sep6_reg;

    always_comb begin
        s6_next = '0;
        r6_next = '0;
        for (int i = 0; i < 3; i++) begin
            s6_next = s6_next + (SW'(pl_hi_reg[i]) <<< L) + SW'(pl_lo_reg[i]);
            r6_next = r6_next + (SW'(pr_hi_reg[i]) <<< L) + SW'(pr_lo_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_reg   <= s6_next;
            r6_reg   <= r6_next;
            sep6_reg <= sep5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: plane test and result register
    // ------------------------------------------------------------------
    logic ovl_next, ovl_reg;

    assign ovl_next = !sep6_reg && !(s6_reg < -r6_reg) && !(s6_reg > r6_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ovl_reg <= ovl_next;
        end
    end

    assign m_tdata = {7'b0, ovl_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[1])
        else $error("accepted request did not enter stage one");

    a_sep_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && valid_reg[NUM_STAGES-1] && sep6_reg |=> m_tvalid && !m_tdata[0])
        else $error("separated triangle reported as overlapping");

endmodule
